// ===== hdl/qf2s_pkg.sv =====
// qf2s_pkg: sizes, types, status codes and helpers for the two-stack queue
// no dependencies; imported by the interfaces and by the top level

package qf2s_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int CAP_W       = 5;
	localparam int WORD_W      = 64;
	localparam int STAT_W      = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CAP_W-1:0]  cap_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam cap_t CAP_RESET = CAP_W'(16);

	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// capacity register limited to the physical depth
	function automatic cnt_t eff_cap(cap_t cap);
		if (int'(cap) > STACK_DEPTH) begin
			return cnt_t'(STACK_DEPTH);
		end
		return cnt_t'(cap);
	endfunction

endpackage

// ===== hdl/qf2s_if.sv =====
// qf2s_if: valid/ready channel interfaces for request, response and configuration
// depends on qf2s_pkg for widths and payload types

interface qf2s_in_if;
	import qf2s_pkg::*;
	logic  valid;
	logic  ready;
	logic  operation;
	word_t push_word;
	modport source (output valid, output operation, output push_word, input ready);
	modport sink   (input valid, input operation, input push_word, output ready);
endinterface

interface qf2s_out_if;
	import qf2s_pkg::*;
	logic    valid;
	logic    ready;
	word_t   pop_word;
	status_t status;
	modport source (output valid, output pop_word, output status, input ready);
	modport sink   (input valid, input pop_word, input status, output ready);
endinterface

interface qf2s_cfg_if;
	import qf2s_pkg::*;
	logic valid;
	logic ready;
	cap_t stack_capacity;
	modport source (output valid, output stack_capacity, input ready);
	modport sink   (input valid, input stack_capacity, output ready);
endinterface

// ===== hdl/qf2s_ram.sv =====
// qf2s_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies; used for both stacks of the queue

module qf2s_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/queue_from_two_stacks.sv =====
// queue_from_two_stacks: fifo of 64-bit words built from an intake and an output stack
// depends on qf2s_pkg, the channel interfaces in qf2s_if and qf2s_ram
//
// usage:
//   req carries one word: operation (push or pop) and push_word.
//   rsp returns exactly one word per request: pop_word and status
//   (done, push dropped on full intake, pop found queue empty).
//   cfg writes stack_capacity at any handshake; write it only while idle.
//   cfg.ready is always high.
// sequence:
//   requests are handled one at a time. a push passes through exec and
//   done before its word is registered on rsp; a pop served from a filled
//   output stack passes through exec, data and done. a pop that finds the
//   output stack empty first moves the n intake words in refill at one word
//   per cycle through the intake ram read port. the next request is taken
//   once the block is back in idle, which it enters as its result is registered.
// reset:
//   arst_n clears both counts, sets capacity to 16; ram contents are kept.
// stall:
//   a held rsp word keeps the output register; one more request may be
//   accepted and worked, then the block waits until rsp is taken.

module queue_from_two_stacks (
	input  logic              clk,
	input  logic              arst_n,
	qf2s_cfg_if.sink          cfg,
	qf2s_in_if.sink           req,
	qf2s_out_if.source        rsp
);
	import qf2s_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_REFILL = 5'b00100,
		S_DATA   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	state_t  state_q;
	logic    op_q;
	word_t   word_q;
	cap_t    cap_q;
	cnt_t    in_cnt_q;
	cnt_t    out_cnt_q;
	logic    mv_s1;
	word_t   res_word_q;
	status_t res_status_q;
	logic    out_valid_q;
	word_t   out_word_q;
	status_t out_status_q;

	cnt_t  eff;
	cnt_t  in_top;
	cnt_t  out_top;
	logic  in_we;
	logic  in_re;
	word_t in_rdata;
	logic  out_we;
	logic  out_re;
	word_t out_rdata;
	logic  load;
	logic  drained;

	assign eff     = eff_cap(cap_q);
	assign in_top  = in_cnt_q - 1'b1;
	assign out_top = out_cnt_q - 1'b1;
	assign out_we  = mv_s1 && (out_cnt_q < eff);
	assign drained = (in_cnt_q == '0) && !mv_s1;
	assign load    = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign req.ready    = (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign rsp.valid    = out_valid_q;
	assign rsp.pop_word = out_word_q;
	assign rsp.status   = out_status_q;

	always_comb begin
		in_we  = 1'b0;
		in_re  = 1'b0;
		out_re = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == OP_PUSH) begin
					in_we = (in_cnt_q < eff);
				end else begin
					out_re = (out_cnt_q != '0);
				end
			end
			S_REFILL: begin
				in_re  = (in_cnt_q != '0);
				out_re = drained && (out_cnt_q != '0);
			end
			default: begin
			end
		endcase
	end

	qf2s_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_intake (
		.clk   (clk),
		.we    (in_we),
		.waddr (in_cnt_q[ADDR_W-1:0]),
		.wdata (word_q),
		.re    (in_re),
		.raddr (in_top[ADDR_W-1:0]),
		.rdata (in_rdata)
	);

	qf2s_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_output (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_cnt_q[ADDR_W-1:0]),
		.wdata (in_rdata),
		.re    (out_re),
		.raddr (out_top[ADDR_W-1:0]),
		.rdata (out_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.stack_capacity;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
			mv_s1     <= 1'b0;
		end else begin
			mv_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_PUSH) begin
						if (in_we) begin
							in_cnt_q <= in_cnt_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (out_cnt_q != '0) begin
						out_cnt_q <= out_top;
						state_q   <= S_DATA;
					end else if (in_cnt_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_REFILL;
					end
				end
				S_REFILL: begin
					mv_s1 <= in_re;
					if (in_re) begin
						in_cnt_q <= in_top;
					end
					if (out_we) begin
						out_cnt_q <= out_cnt_q + 1'b1;
					end
					if (drained) begin
						if (out_cnt_q != '0) begin
							out_cnt_q <= out_top;
							state_q   <= S_DATA;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DATA: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.operation;
			word_q <= req.push_word;
		end
		if (state_q == S_EXEC) begin
			res_word_q   <= '0;
			res_status_q <= (op_q == OP_PUSH) ? ((in_cnt_q < eff) ? ST_DONE : ST_FULL)
			                                  : ST_EMPTY;
		end
		if (state_q == S_DATA) begin
			res_word_q   <= out_rdata;
			res_status_q <= ST_DONE;
		end
		if (load) begin
			out_word_q   <= res_word_q;
			out_status_q <= res_status_q;
		end
	end

	a_in_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(in_cnt_q) <= STACK_DEPTH)
		else $error("intake count above depth");

	a_out_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(out_cnt_q) <= STACK_DEPTH)
		else $error("output count above depth");

	a_move_in_refill: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> (state_q == S_REFILL))
		else $error("word move outside refill");

	a_data_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> $past(out_re))
		else $error("pop data without a read of the output stack");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == S_EXEC))
		else $error("accepted word not started");

endmodule

// ===== verif/queue_from_two_stacks_test.sv =====
`timescale 1ns / 1ps
// queue_from_two_stacks_test: self-checking bench for the two-stack fifo, with a
// clocked driver, a stalling monitor and an in-bench predictor of both stacks
// depends on qf2s_pkg, the channel interfaces in qf2s_if and queue_from_two_stacks

module queue_from_two_stacks_test;
	import qf2s_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 64;

	typedef struct packed {
		logic  op;
		word_t data;
	} request_t;

	typedef struct packed {
		word_t   data;
		status_t status;
	} result_t;

	logic clk;
	logic arst_n;

	qf2s_cfg_if cfg_bus ();
	qf2s_in_if  req_bus ();
	qf2s_out_if rsp_bus ();

	queue_from_two_stacks DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	request_t request_queue[$];
	result_t  pending_results[$];

	word_t intake_words[STACK_DEPTH];
	word_t output_words[STACK_DEPTH];
	int    intake_fill;
	int    output_fill;
	cap_t  capacity_reg;

	int          errors;
	int          burst_left;
	int          gap_left;
	int          idle_cycles;
	logic [15:0] rsp_cycle;

	function automatic result_t serve_request(request_t r);
		int      cap;
		result_t res;
		cap = (int'(capacity_reg) > STACK_DEPTH) ? STACK_DEPTH : int'(capacity_reg);
		res.data = '0;
		res.status = ST_DONE;
		if (r.op == OP_PUSH) begin
			if (intake_fill >= cap) begin
				res.status = ST_FULL;
			end else begin
				intake_words[intake_fill] = r.data;
				intake_fill++;
			end
		end else begin
			// refill reverses order; entries that no longer fit are lost
			if (output_fill == 0) begin
				while (intake_fill > 0) begin
					intake_fill--;
					if (output_fill < cap) begin
						output_words[output_fill] = intake_words[intake_fill];
						output_fill++;
					end
				end
			end
			if (output_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				output_fill--;
				res.data = output_words[output_fill];
			end
		end
		return res;
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_push(word_t w);
		request_t r;
		r.op = OP_PUSH;
		r.data = w;
		request_queue.push_back(r);
	endtask

	task automatic add_pop();
		request_t r;
		r.op = OP_POP;
		r.data = rand_word();
		request_queue.push_back(r);
	endtask

	task automatic drain();
		while (request_queue.size() != 0 || req_bus.valid || pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_capacity(cap_t v);
		drain();
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.stack_capacity <= v;
		do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
		capacity_reg = v;
		cfg_bus.valid <= 1'b0;
	endtask

	// mostly fill-then-drain runs, with some unordered noise
	task automatic fill_random(int n);
		int added;
		int k;
		int j;
		added = 0;
		while (added < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					k = $urandom_range(1, 20);
					j = $urandom_range(1, k + 2);
					repeat (k) add_push(rand_word());
					repeat (j) add_pop();
					added += k + j;
				end
				6, 7: begin
					repeat (10) begin
						if ($urandom_range(0, 1) == 0) add_push(rand_word());
						else add_pop();
					end
					added += 10;
				end
				8: begin
					k = $urandom_range(1, 20);
					repeat (k) add_pop();
					added += k;
				end
				default: begin
					k = $urandom_range(1, 20);
					repeat (k) add_push(rand_word());
					added += k;
				end
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin : driver
		request_t nxt;
		bit       load;
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			load = !req_bus.valid;
			if (req_bus.valid && req_bus.ready) begin
				nxt.op = req_bus.operation;
				nxt.data = req_bus.push_word;
				pending_results.push_back(serve_request(nxt));
				load = 1'b1;
			end
			if (load) begin
				if (gap_left > 0) begin
					gap_left--;
					req_bus.valid <= 1'b0;
				end else if (request_queue.size() == 0) begin
					req_bus.valid <= 1'b0;
				end else begin
					nxt = request_queue.pop_front();
					req_bus.valid <= 1'b1;
					req_bus.operation <= nxt.op;
					req_bus.push_word <= nxt.data;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
							: $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			rsp_cycle <= '0;
		end else begin
			rsp_cycle <= rsp_cycle + 1'b1;
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected word pop_word=%h status=%0d", $time,
						rsp_bus.pop_word, rsp_bus.status);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (rsp_bus.pop_word !== want.data) begin
						$display("%0t: pop_word expected %h actual %h", $time,
							want.data, rsp_bus.pop_word);
						errors++;
					end
					if (rsp_bus.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, rsp_bus.status);
						errors++;
					end
				end
			end
			case (rsp_cycle[9:8])
				2'd0: rsp_bus.ready <= 1'b1;
				2'd1: rsp_bus.ready <= ($urandom_range(0, 1) == 0);
				2'd2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
				default: rsp_bus.ready <= rsp_cycle[2];
			endcase
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("queue_from_two_stacks: mismatch");
				$finish;
			end
		end
	end

	initial begin
		cap_t caps[$];
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.operation = OP_PUSH;
		req_bus.push_word = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.stack_capacity = CAP_RESET;
		rsp_bus.ready = 1'b0;
		capacity_reg = CAP_RESET;
		intake_fill = 0;
		output_fill = 0;
		errors = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset capacity: empty pop, extreme words, refill order
		add_pop();
		add_push('1);
		add_push('0);
		add_push(64'hA5A5_5A5A_C3C3_3C3C);
		add_pop();
		add_pop();
		add_push(64'h1);
		add_pop();
		add_pop();
		add_pop();

		// full intake drops the word
		write_capacity(5'd2);
		repeat (3) add_push(rand_word());
		repeat (3) add_pop();

		// zero capacity
		write_capacity(5'd0);
		add_push(rand_word());
		add_pop();

		// capacity lowered while intake is filled, then output served at zero
		write_capacity(5'd16);
		repeat (5) add_push(rand_word());
		write_capacity(5'd2);
		add_pop();
		write_capacity(5'd0);
		add_pop();
		add_pop();

		// refill that lands nothing
		write_capacity(5'd16);
		repeat (3) add_push(rand_word());
		write_capacity(5'd0);
		add_pop();

		caps = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd17, 5'd2, 5'd16,
			cap_t'($urandom_range(1, 16)), cap_t'($urandom_range(1, 16)),
			cap_t'($urandom_range(1, 16)), 5'd3};
		foreach (caps[i]) begin
			write_capacity(caps[i]);
			fill_random((caps[i] == 5'd0) ? 40 : 155);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("queue_from_two_stacks: match");
		end else begin
			$display("queue_from_two_stacks: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/qf2s_pkg.sv
hdl/qf2s_if.sv
hdl/qf2s_ram.sv
hdl/queue_from_two_stacks.sv
verif/queue_from_two_stacks_test.sv
